FILE: rtl/core/lcadc_pkg.sv
// Shared types and constants of the load cell ADC reader.
package lcadc_pkg;

  localparam int unsigned WEIGHT_W = 24;
  localparam int unsigned SCALE_W  = 16;
  localparam int unsigned LIMIT_W  = 24;
  localparam int unsigned ACTION_W = 2;
  localparam int unsigned APB_AW   = 3;
  localparam int unsigned APB_DW   = 32;

  localparam logic [WEIGHT_W-1:0] WEIGHT_MAX = 24'hFFFFFF;

  localparam logic [SCALE_W-1:0] SCALE_RST = 16'd440;
  localparam logic [LIMIT_W-1:0] LIMIT_RST = 24'd3000;

  localparam logic [ACTION_W-1:0] ACT_NONE    = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_MEASURE = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_TARE    = 2'd2;

  localparam logic REG_SCALE = 1'b0;
  localparam logic REG_LIMIT = 1'b1;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'b001,
    PH_WAIT  = 3'b010,
    PH_SHIFT = 3'b100
  } phase_e;

  typedef struct packed {
    logic tick;
    logic div_step;
    logic div_commit;
  } lcadc_cmd_t;

  typedef struct packed {
    logic div_start;
    logic div_last;
  } lcadc_sts_t;

endpackage

FILE: rtl/core/lcadc_ctrl.sv
// Sequencing state machine: request handshake, divider run and result handshake.
module lcadc_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  input  lcadc_pkg::lcadc_sts_t sts_i,
  output lcadc_pkg::lcadc_cmd_t cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_DIV  = 4'b0010,
    ST_WB   = 4'b0100,
    ST_OUT  = 4'b1000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d           = state_q;
    in_ready_o        = 1'b0;
    out_valid_o       = 1'b0;
    cmd_o.tick        = 1'b0;
    cmd_o.div_step    = 1'b0;
    cmd_o.div_commit  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.tick = 1'b1;
          state_d    = sts_i.div_start ? ST_DIV : ST_OUT;
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = ST_WB;
        end
      end
      ST_WB: begin
        cmd_o.div_commit = 1'b1;
        state_d          = ST_OUT;
      end
      ST_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: rtl/core/lcadc_dp.sv
// Datapath: serial clock sequencing, data shift register, tare and scaling divider.
module lcadc_dp #(
  parameter int unsigned DATA_BITS = 24
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  lcadc_pkg::lcadc_cmd_t              cmd_i,
  output lcadc_pkg::lcadc_sts_t              sts_o,
  input  logic [lcadc_pkg::ACTION_W-1:0]     action_i,
  input  logic                               dout_i,
  input  logic [lcadc_pkg::SCALE_W-1:0]      scale_divisor_i,
  input  logic [lcadc_pkg::LIMIT_W-1:0]      overload_limit_i,
  output logic                               sck_o,
  output logic                               busy_res_o,
  output logic                               done_res_o,
  output logic [lcadc_pkg::WEIGHT_W-1:0]     weight_o,
  output logic                               overload_o
);

  localparam int unsigned PW = $clog2(DATA_BITS + 2);
  localparam int unsigned CW = $clog2(DATA_BITS);
  localparam int unsigned QW = (DATA_BITS > lcadc_pkg::WEIGHT_W) ? DATA_BITS
                                                                   : lcadc_pkg::WEIGHT_W;
  localparam int unsigned SW = lcadc_pkg::SCALE_W;

  lcadc_pkg::phase_e phase_q, phase_d;
  logic [PW-1:0]                      pulse_q, pulse_d;
  logic                               clk_lvl_q, clk_lvl_d;
  logic [DATA_BITS-1:0]               shift_q, shift_d;
  logic [DATA_BITS-1:0]               tare_q;
  logic                               tare_job_q, tare_job_d;
  logic [lcadc_pkg::WEIGHT_W-1:0]     weight_q;
  logic                               ovl_q;
  logic                               done_q;
  logic                               busy_q;
  logic [CW-1:0]                      cnt_q;
  logic [DATA_BITS-1:0]               dvd_q;
  logic [SW-1:0]                      rem_q;

  logic                               fin;
  logic [DATA_BITS-1:0]               raw;
  logic                               pos;
  logic [DATA_BITS-1:0]               diff;
  logic [SW:0]                        rem_sh;
  logic                               ge;
  logic [SW:0]                        rem_sub;
  logic [QW-1:0]                      q_ext;
  logic                               sat;
  logic [lcadc_pkg::WEIGHT_W-1:0]     q_w;

  always_comb begin
    phase_d    = phase_q;
    pulse_d    = pulse_q;
    clk_lvl_d  = clk_lvl_q;
    shift_d    = shift_q;
    tare_job_d = tare_job_q;
    fin        = 1'b0;
    unique case (phase_q)
      lcadc_pkg::PH_IDLE: begin
        clk_lvl_d = 1'b0;
        if (action_i == lcadc_pkg::ACT_MEASURE || action_i == lcadc_pkg::ACT_TARE) begin
          tare_job_d = (action_i == lcadc_pkg::ACT_TARE);
          phase_d    = lcadc_pkg::PH_WAIT;
        end
      end
      lcadc_pkg::PH_WAIT: begin
        clk_lvl_d = 1'b0;
        if (!dout_i) begin
          phase_d = lcadc_pkg::PH_SHIFT;
          pulse_d = '0;
          shift_d = '0;
        end
      end
      lcadc_pkg::PH_SHIFT: begin
        if (!clk_lvl_q) begin
          clk_lvl_d = 1'b1;
        end else begin
          clk_lvl_d = 1'b0;
          if (pulse_q < PW'(DATA_BITS)) begin
            shift_d = {shift_q[DATA_BITS-2:0], dout_i};
          end
          pulse_d = pulse_q + PW'(1);
          if (pulse_q == PW'(DATA_BITS)) begin
            fin     = 1'b1;
            phase_d = lcadc_pkg::PH_IDLE;
            pulse_d = '0;
          end
        end
      end
      default: begin
        phase_d   = lcadc_pkg::PH_IDLE;
        clk_lvl_d = 1'b0;
      end
    endcase
  end

  assign raw  = shift_q ^ {1'b1, {(DATA_BITS-1){1'b0}}};
  assign pos  = raw > tare_q;
  assign diff = raw - tare_q;

  assign sts_o.div_start = fin && !tare_job_q && pos;
  assign sts_o.div_last  = (cnt_q == CW'(DATA_BITS - 1));

  assign rem_sh  = {rem_q, dvd_q[DATA_BITS-1]};
  assign ge      = rem_sh >= {1'b0, scale_divisor_i};
  assign rem_sub = rem_sh - {1'b0, scale_divisor_i};

  assign q_ext = QW'(dvd_q);
  assign sat   = (scale_divisor_i == '0) || (q_ext > QW'(lcadc_pkg::WEIGHT_MAX));
  assign q_w   = sat ? lcadc_pkg::WEIGHT_MAX : q_ext[lcadc_pkg::WEIGHT_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= lcadc_pkg::PH_IDLE;
      pulse_q    <= '0;
      clk_lvl_q  <= 1'b0;
      shift_q    <= '0;
      tare_q     <= '0;
      tare_job_q <= 1'b0;
      weight_q   <= '0;
      ovl_q      <= 1'b0;
      done_q     <= 1'b0;
      busy_q     <= 1'b0;
      cnt_q      <= '0;
    end else begin
      if (cmd_i.tick) begin
        phase_q    <= phase_d;
        pulse_q    <= pulse_d;
        clk_lvl_q  <= clk_lvl_d;
        shift_q    <= shift_d;
        tare_job_q <= tare_job_d;
        done_q     <= fin;
        busy_q     <= (phase_d != lcadc_pkg::PH_IDLE);
        cnt_q      <= '0;
        if (fin) begin
          if (tare_job_q) begin
            tare_q <= raw;
          end else if (!pos) begin
            weight_q <= '0;
          end
        end
      end
      if (cmd_i.div_step) begin
        cnt_q <= cnt_q + CW'(1);
      end
      if (cmd_i.div_commit) begin
        weight_q <= q_w;
        ovl_q    <= q_w > overload_limit_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.tick && sts_o.div_start) begin
      dvd_q <= diff;
      rem_q <= '0;
    end else if (cmd_i.div_step) begin
      dvd_q <= {dvd_q[DATA_BITS-2:0], ge};
      rem_q <= ge ? rem_sub[SW-1:0] : rem_sh[SW-1:0];
    end
  end

  assign sck_o      = clk_lvl_q;
  assign busy_res_o = busy_q;
  assign done_res_o = done_q;
  assign weight_o   = weight_q;
  assign overload_o = ovl_q;

endmodule

FILE: rtl/core/load_cell_adc_reader.sv
// Top level of the load cell ADC reader with its configuration registers.
// A tick request presents its result in the cycle after acceptance; the tick that completes
// a measurement with a positive tared reading first runs the one-bit-per-cycle restoring
// divider through the DIV and WB states. The next request is taken in the cycle after the
// result is taken; no new request is taken while one is still in flight.
// Reset is asynchronous and active low; all but the divider registers return to defaults.
module load_cell_adc_reader #(
  parameter int unsigned DATA_BITS = 24
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [lcadc_pkg::ACTION_W-1:0]      action_i,
  input  logic                                dout_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic                                sck_o,
  output logic                                busy_res_o,
  output logic                                done_res_o,
  output logic [lcadc_pkg::WEIGHT_W-1:0]      weight_o,
  output logic                                overload_o,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [lcadc_pkg::APB_AW-1:0]        paddr,
  input  logic [lcadc_pkg::APB_DW-1:0]        pwdata,
  output logic [lcadc_pkg::APB_DW-1:0]        prdata,
  output logic                                pready
);

  logic [lcadc_pkg::SCALE_W-1:0] scale_q;
  logic [lcadc_pkg::LIMIT_W-1:0] limit_q;
  logic                          wr_en;
  lcadc_pkg::lcadc_cmd_t         cmd;
  lcadc_pkg::lcadc_sts_t         sts;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q <= lcadc_pkg::SCALE_RST;
      limit_q <= lcadc_pkg::LIMIT_RST;
    end else if (wr_en) begin
      if (paddr[2] == lcadc_pkg::REG_SCALE) begin
        scale_q <= pwdata[lcadc_pkg::SCALE_W-1:0];
      end else begin
        limit_q <= pwdata[lcadc_pkg::LIMIT_W-1:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == lcadc_pkg::REG_LIMIT) begin
      prdata = lcadc_pkg::APB_DW'(limit_q);
    end else begin
      prdata = lcadc_pkg::APB_DW'(scale_q);
    end
  end

  lcadc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  lcadc_dp #(
    .DATA_BITS (DATA_BITS)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .action_i         (action_i),
    .dout_i           (dout_i),
    .scale_divisor_i  (scale_q),
    .overload_limit_i (limit_q),
    .sck_o            (sck_o),
    .busy_res_o       (busy_res_o),
    .done_res_o       (done_res_o),
    .weight_o         (weight_o),
    .overload_o       (overload_o)
  );

endmodule
